/* rtl/ptb_pkg.sv */
// Shared types and constants for the periodic timer bank.
package ptb_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int SLOT_W        = 3;
	localparam int MASK_W        = 8;
	localparam int MS_W          = 32;

	// command codes
	localparam logic [2:0] MODE_CREATE = 3'd0;
	localparam logic [2:0] MODE_START  = 3'd1;
	localparam logic [2:0] MODE_STOP   = 3'd2;
	localparam logic [2:0] MODE_DELETE = 3'd3;
	localparam logic [2:0] MODE_TICK   = 3'd4;

	// slot states
	localparam logic [1:0] SLOT_FREE = 2'd0;
	localparam logic [1:0] SLOT_SUSP = 2'd1;
	localparam logic [1:0] SLOT_RUN  = 2'd2;

	typedef struct packed {
		logic [1:0]      state;
		logic [MS_W-1:0] period;
		logic [MS_W-1:0] start;
		logic            started;
	} slot_entry_t;

	typedef struct packed {
		logic              status;
		logic [SLOT_W-1:0] slot;
		logic [MASK_W-1:0] fired_mask;
	} result_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DRAIN,
		FSM_FINISH
	} fsm_t;

endpackage

/* rtl/periodic_timer_bank_core.sv */
// Periodic timer bank top level: slot table, command sequencer, output register.
//
// Input channel (in_valid / in_stall) carries one command per transfer:
// mode, period (the timer key) and now_ms (used by tick only). Each command
// yields exactly one result on the output channel (out_valid / out_stall):
// status, slot and, for tick, fired_mask with one bit per fired slot.
// All timer state sits in a single slot table memory with a registered read.
// A command reads every slot in order, one per cycle, modifies and writes
// back; create, start, stop and delete write their one slot at the end.
// The result passes through the scan, drain and finish states into the
// output register; a new command is taken only once the sequencer is
// back in idle.
// in_stall stays high while a command is in progress. A finished result is
// held in the output register; a stalled receiver holds it there, the next
// command still enters and scans, and it waits at its end only if the
// register is still occupied.
// Reset clears all slots to free at once through per-entry valid bits;
// no clearing pass is needed and commands are taken right after reset.
module periodic_timer_bank_core import ptb_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        mode,
	input  logic [MS_W-1:0]   period,
	input  logic [MS_W-1:0]   now_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              status,
	output logic [SLOT_W-1:0] slot,
	output logic [MASK_W-1:0] fired_mask
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic        mem_rd_en;
	logic [IW-1:0] mem_rd_addr;
	slot_entry_t mem_rd_data;
	logic        mem_wr_en;
	logic [IW-1:0] mem_wr_addr;
	slot_entry_t mem_wr_data;
	logic        res_valid;
	logic        res_ready;
	result_t     res;

	ptb_mem #(
		.NUM_SLOTS (NUM_SLOTS),
		.IW        (IW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	ptb_ctrl #(
		.NUM_SLOTS (NUM_SLOTS),
		.IW        (IW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.period      (period),
		.now_ms      (now_ms),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.res_valid   (res_valid),
		.res         (res),
		.res_ready   (res_ready)
	);

	ptb_outreg u_outreg (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (res_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.slot       (slot),
		.fired_mask (fired_mask)
	);

endmodule

/* rtl/ptb_mem.sv */
// Slot table memory with registered read and per-entry valid bits.
module ptb_mem import ptb_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [IW-1:0]     rd_addr,
	output slot_entry_t       rd_data,
	input  logic              wr_en,
	input  logic [IW-1:0]     wr_addr,
	input  slot_entry_t       wr_data
);

	slot_entry_t            mem [NUM_SLOTS];
	slot_entry_t            rdata_q;
	logic [NUM_SLOTS-1:0]   valid_q;
	logic                   rvalid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// entries never written read as the reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

/* rtl/ptb_ctrl.sv */
// Command sequencer: scans the slot table one entry per cycle and writes back.
module ptb_ctrl import ptb_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [2:0]      mode,
	input  logic [MS_W-1:0] period,
	input  logic [MS_W-1:0] now_ms,
	output logic            mem_rd_en,
	output logic [IW-1:0]   mem_rd_addr,
	input  slot_entry_t     mem_rd_data,
	output logic            mem_wr_en,
	output logic [IW-1:0]   mem_wr_addr,
	output slot_entry_t     mem_wr_data,
	output logic            res_valid,
	output result_t         res,
	input  logic            res_ready
);

	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

	fsm_t              state_q, state_d;
	logic              accept;
	logic              finish_go;

	logic [2:0]        mode_q;
	logic [MS_W-1:0]   key_q;
	logic [MS_W-1:0]   now_q;
	logic [IW-1:0]     rd_idx_q;

	logic              valid_s1;
	logic [IW-1:0]     idx_s1;

	logic              dup_q;
	logic              free_found_q;
	logic [IW-1:0]     free_idx_q;
	logic              hit_found_q;
	logic [IW-1:0]     hit_idx_q;
	slot_entry_t       hit_ent_q;
	logic [MASK_W-1:0] mask_q;

	logic              is_free;
	logic              is_cmd;
	slot_entry_t       tick_ent;
	logic              tick_fire;
	logic              tick_wr;
	logic [MS_W-1:0]   start_eff;
	logic [MS_W-1:0]   elapsed;
	slot_entry_t       cmd_ent;
	logic              fin_wr;

	assign accept = in_valid && !in_stall;
	assign is_cmd = (mode_q inside {MODE_START, MODE_STOP, MODE_DELETE});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) state_d = FSM_SCAN;
			end
			FSM_SCAN: begin
				if (rd_idx_q == LAST_IDX) state_d = FSM_DRAIN;
			end
			FSM_DRAIN: begin
				state_d = FSM_FINISH;
			end
			FSM_FINISH: begin
				if (res_ready) state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_stall  = 1'b1;
		mem_rd_en = 1'b0;
		finish_go = 1'b0;
		case (state_q)
			FSM_IDLE:   in_stall  = 1'b0;
			FSM_SCAN:   mem_rd_en = 1'b1;
			FSM_DRAIN:  ;
			FSM_FINISH: finish_go = res_ready;
			default:    ;
		endcase
	end

	assign mem_rd_addr = rd_idx_q;
	assign res_valid   = finish_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FSM_IDLE;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= mem_rd_en;
		end
	end

	// per-entry evaluation of the entry read last cycle
	assign is_free   = (mem_rd_data.state == SLOT_FREE);
	assign start_eff = mem_rd_data.started ? mem_rd_data.start : now_q;
	assign elapsed   = now_q - start_eff;
	assign tick_fire = (elapsed >= mem_rd_data.period);
	assign tick_wr   = valid_s1 && (mode_q == MODE_TICK) && (mem_rd_data.state == SLOT_RUN);

	always_comb begin
		tick_ent         = mem_rd_data;
		tick_ent.started = 1'b1;
		tick_ent.start   = tick_fire ? now_q : start_eff;
	end

	always_comb begin
		cmd_ent = hit_ent_q;
		case (mode_q)
			MODE_START:  cmd_ent.state = SLOT_RUN;
			MODE_STOP:   cmd_ent.state = SLOT_SUSP;
			MODE_DELETE: begin
				cmd_ent.state  = SLOT_FREE;
				cmd_ent.period = '0;
			end
			default:     ;
		endcase
	end

	always_comb begin
		fin_wr = 1'b0;
		if (finish_go) begin
			if (mode_q == MODE_CREATE) fin_wr = !dup_q && free_found_q;
			else if (is_cmd)           fin_wr = hit_found_q;
		end
	end

	// scan writes and finish writes never fall in the same cycle
	always_comb begin
		mem_wr_en   = tick_wr || fin_wr;
		mem_wr_addr = idx_s1;
		mem_wr_data = tick_ent;
		if (fin_wr) begin
			if (mode_q == MODE_CREATE) begin
				mem_wr_addr         = free_idx_q;
				mem_wr_data.state   = SLOT_SUSP;
				mem_wr_data.period  = key_q;
				mem_wr_data.start   = '0;
				mem_wr_data.started = 1'b0;
			end else begin
				mem_wr_addr = hit_idx_q;
				mem_wr_data = cmd_ent;
			end
		end
	end

	always_comb begin
		res = '0;
		case (mode_q)
			MODE_CREATE: begin
				res.status = dup_q || !free_found_q;
				res.slot   = res.status ? '0 : SLOT_W'(free_idx_q);
			end
			MODE_START, MODE_STOP, MODE_DELETE: begin
				res.status = !hit_found_q;
				res.slot   = hit_found_q ? SLOT_W'(hit_idx_q) : '0;
			end
			MODE_TICK: begin
				res.fired_mask = mask_q;
			end
			default: begin
				res.status = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (accept) begin
			mode_q       <= mode;
			key_q        <= period;
			now_q        <= now_ms;
			rd_idx_q     <= '0;
			dup_q        <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			hit_found_q  <= 1'b0;
			hit_idx_q    <= '0;
			mask_q       <= '0;
		end else begin
			if (mem_rd_en && rd_idx_q != LAST_IDX) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (valid_s1) begin
				if (mem_rd_data.period == key_q) begin
					dup_q <= 1'b1;
				end
				if (!free_found_q && is_free) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
				// first in-use slot with a matching period
				if (!hit_found_q && !is_free && mem_rd_data.period == key_q) begin
					hit_found_q <= 1'b1;
					hit_idx_q   <= idx_s1;
					hit_ent_q   <= mem_rd_data;
				end
				// slots from eight up shift out of the mask
				if (tick_wr && tick_fire) begin
					mask_q <= mask_q | (MASK_W'(1) << idx_s1);
				end
			end
		end
	end

endmodule

/* rtl/ptb_outreg.sv */
// Result output register between the sequencer and the downstream receiver.
module ptb_outreg import ptb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  result_t           res,
	output logic              res_ready,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              status,
	output logic [SLOT_W-1:0] slot,
	output logic [MASK_W-1:0] fired_mask
);

	logic    valid_q;
	result_t data_q;

	// load when empty or when the held result leaves this cycle
	assign res_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

	assign out_valid  = valid_q;
	assign status     = data_q.status;
	assign slot       = data_q.slot;
	assign fired_mask = data_q.fired_mask;

endmodule
